### hdl/bqdf2_pkg.sv
package bqdf2_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 32;
	localparam int DATA_WIDTH   = 32;
	localparam int FRAC_INT     = 23;
	localparam int COEF_FRAC    = COEF_WIDTH - 3;
	localparam int NUM_REGS     = 5;
	localparam int INDEX_WIDTH  = $clog2(NUM_REGS);

	localparam int PROD_WIDTH   = COEF_WIDTH + DATA_WIDTH;
	localparam int TERM_WIDTH   = PROD_WIDTH - COEF_FRAC;
	localparam int ACC_WIDTH    = TERM_WIDTH + 2;
	localparam int CPROD_WIDTH  = 2 * COEF_WIDTH;
	localparam int CTERM_WIDTH  = CPROD_WIDTH - COEF_FRAC;
	localparam int CDIFF_WIDTH  = CTERM_WIDTH + 1;

	localparam int ALIGN_SHL = (SAMPLE_WIDTH <= FRAC_INT + 1) ? FRAC_INT + 1 - SAMPLE_WIDTH : 0;
	localparam int ALIGN_SHR = (SAMPLE_WIDTH > FRAC_INT + 1) ? SAMPLE_WIDTH - FRAC_INT - 1 : 0;

	typedef enum logic [INDEX_WIDTH-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2
	} reg_index_t;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		coef_t b0;
		coef_t a1;
		coef_t a2;
		coef_t c1;
		coef_t c2;
		logic  busy;
	} coef_bus_t;

	typedef struct packed {
		logic  hit;
		data_t val;
	} sat_data_t;

	// coefficient times data, rounded half away from zero
	function automatic logic signed [TERM_WIDTH-1:0] mul_rnd_data(input coef_t c, input data_t v);
		logic signed [PROD_WIDTH-1:0] p;
		logic signed [PROD_WIDTH-1:0] r;
		p = PROD_WIDTH'(c) * PROD_WIDTH'(v);
		r = p + (PROD_WIDTH'(1) <<< (COEF_FRAC - 1)) - PROD_WIDTH'(p[PROD_WIDTH-1]);
		return TERM_WIDTH'(r >>> COEF_FRAC);
	endfunction

	// coefficient times coefficient, rounded half away from zero
	function automatic logic signed [CTERM_WIDTH-1:0] mul_rnd_coef(input coef_t c, input coef_t d);
		logic signed [CPROD_WIDTH-1:0] p;
		logic signed [CPROD_WIDTH-1:0] r;
		p = CPROD_WIDTH'(c) * CPROD_WIDTH'(d);
		r = p + (CPROD_WIDTH'(1) <<< (COEF_FRAC - 1)) - CPROD_WIDTH'(p[CPROD_WIDTH-1]);
		return CTERM_WIDTH'(r >>> COEF_FRAC);
	endfunction

	function automatic sat_data_t sat_data(input logic signed [ACC_WIDTH-1:0] v);
		logic      all_ones;
		logic      all_zeros;
		sat_data_t s;
		all_ones  = &v[ACC_WIDTH-1:DATA_WIDTH-1];
		all_zeros = ~|v[ACC_WIDTH-1:DATA_WIDTH-1];
		s.hit     = !(all_ones || all_zeros);
		if (s.hit) begin
			s.val = {v[ACC_WIDTH-1], {(DATA_WIDTH-1){~v[ACC_WIDTH-1]}}};
		end else begin
			s.val = v[DATA_WIDTH-1:0];
		end
		return s;
	endfunction

	function automatic coef_t sat_coef(input logic signed [CDIFF_WIDTH-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[CDIFF_WIDTH-1:COEF_WIDTH-1];
		all_zeros = ~|v[CDIFF_WIDTH-1:COEF_WIDTH-1];
		if (all_ones || all_zeros) begin
			return v[COEF_WIDTH-1:0];
		end
		return {v[CDIFF_WIDTH-1], {(COEF_WIDTH-1){~v[CDIFF_WIDTH-1]}}};
	endfunction

	// sample to q9.23, surplus fraction bits floored
	function automatic data_t align_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
		data_t e;
		e = DATA_WIDTH'(s);
		return (e <<< ALIGN_SHL) >>> ALIGN_SHR;
	endfunction

endpackage

### hdl/biquad_direct_form_two_filter_core.sv
// channel  | handshake              | payload
// config   | cfg_wr_en              | cfg_index, cfg_wr_data
// input    | in_valid / in_ready    | sample_in
// output   | out_valid / out_ready  | sample_out, clipped
//
// one sample per cycle sustained while out_ready is high and no register write stalls
// the rate is set by the delay recursion: two multipliers and the sum, all combinational
// a register write stalls the sample stage while the cross terms update
// input register and result register let a new sample enter while a result waits
// arst_n clears coefficients, cross terms and delay line to zero
module biquad_direct_form_two_filter_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [bqdf2_pkg::INDEX_WIDTH-1:0]         cfg_index,
	input  logic [bqdf2_pkg::COEF_WIDTH-1:0]          cfg_wr_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [bqdf2_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [bqdf2_pkg::DATA_WIDTH-1:0]   sample_out,
	output logic                                      clipped
);

	bqdf2_pkg::coef_bus_t coef_bus;

	bqdf2_coef_bank u_coef (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.coef_bus    (coef_bus)
	);

	bqdf2_section u_section (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_bus   (coef_bus),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

endmodule

### hdl/bqdf2_coef_bank.sv
module bqdf2_coef_bank (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [bqdf2_pkg::INDEX_WIDTH-1:0]      cfg_index,
	input  logic [bqdf2_pkg::COEF_WIDTH-1:0]       cfg_wr_data,
	output bqdf2_pkg::coef_bus_t                   coef_bus
);

	bqdf2_pkg::coef_t b0_q;
	bqdf2_pkg::coef_t b1_q;
	bqdf2_pkg::coef_t b2_q;
	bqdf2_pkg::coef_t a1_q;
	bqdf2_pkg::coef_t a2_q;
	bqdf2_pkg::coef_t c1_q;
	bqdf2_pkg::coef_t c2_q;
	logic             busy_q;

	bqdf2_pkg::coef_t c1_next;
	bqdf2_pkg::coef_t c2_next;

	// cross terms b1 - b0*a1 and b2 - b0*a2
	always_comb begin
		c1_next = bqdf2_pkg::sat_coef(bqdf2_pkg::CDIFF_WIDTH'(b1_q)
			- bqdf2_pkg::CDIFF_WIDTH'(bqdf2_pkg::mul_rnd_coef(b0_q, a1_q)));
		c2_next = bqdf2_pkg::sat_coef(bqdf2_pkg::CDIFF_WIDTH'(b2_q)
			- bqdf2_pkg::CDIFF_WIDTH'(bqdf2_pkg::mul_rnd_coef(b0_q, a2_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q   <= '0;
			b1_q   <= '0;
			b2_q   <= '0;
			a1_q   <= '0;
			a2_q   <= '0;
			c1_q   <= '0;
			c2_q   <= '0;
			busy_q <= 1'b0;
		end else begin
			c1_q   <= c1_next;
			c2_q   <= c2_next;
			busy_q <= cfg_wr_en;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					bqdf2_pkg::REG_B0: b0_q <= cfg_wr_data;
					bqdf2_pkg::REG_B1: b1_q <= cfg_wr_data;
					bqdf2_pkg::REG_B2: b2_q <= cfg_wr_data;
					bqdf2_pkg::REG_A1: a1_q <= cfg_wr_data;
					bqdf2_pkg::REG_A2: a2_q <= cfg_wr_data;
					default: ;
				endcase
			end
		end
	end

	assign coef_bus.b0   = b0_q;
	assign coef_bus.a1   = a1_q;
	assign coef_bus.a2   = a2_q;
	assign coef_bus.c1   = c1_q;
	assign coef_bus.c2   = c2_q;
	assign coef_bus.busy = busy_q;

endmodule

### hdl/bqdf2_section.sv
module bqdf2_section (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bqdf2_pkg::coef_bus_t                   coef_bus,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [bqdf2_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [bqdf2_pkg::DATA_WIDTH-1:0] sample_out,
	output logic                                   clipped
);

	logic                valid_s1;
	bqdf2_pkg::data_t    x_s1;
	bqdf2_pkg::data_t    m1_q;
	bqdf2_pkg::data_t    m2_q;
	logic                out_valid_q;
	bqdf2_pkg::data_t    y_q;
	logic                clip_q;

	logic                advance;
	logic                commit;
	logic signed [bqdf2_pkg::ACC_WIDTH-1:0] y_acc;
	logic signed [bqdf2_pkg::ACC_WIDTH-1:0] m_acc;
	bqdf2_pkg::sat_data_t y_sat;
	bqdf2_pkg::sat_data_t m_sat;

	// hold in the cycle after a register write so the cross terms settle
	assign advance  = (!out_valid_q || out_ready) && !coef_bus.busy;
	assign commit   = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		y_acc = bqdf2_pkg::ACC_WIDTH'(bqdf2_pkg::mul_rnd_data(coef_bus.b0, x_s1))
			+ bqdf2_pkg::ACC_WIDTH'(bqdf2_pkg::mul_rnd_data(coef_bus.c1, m1_q))
			+ bqdf2_pkg::ACC_WIDTH'(bqdf2_pkg::mul_rnd_data(coef_bus.c2, m2_q));
		m_acc = bqdf2_pkg::ACC_WIDTH'(x_s1)
			- bqdf2_pkg::ACC_WIDTH'(bqdf2_pkg::mul_rnd_data(coef_bus.a1, m1_q))
			- bqdf2_pkg::ACC_WIDTH'(bqdf2_pkg::mul_rnd_data(coef_bus.a2, m2_q));
		y_sat = bqdf2_pkg::sat_data(y_acc);
		m_sat = bqdf2_pkg::sat_data(m_acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			m1_q        <= '0;
			m2_q        <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				m1_q <= m_sat.val;
				m2_q <= m1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1 <= bqdf2_pkg::align_sample(sample_in);
		end
		if (commit) begin
			y_q    <= y_sat.val;
			clip_q <= y_sat.hit || m_sat.hit;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = y_q;
	assign clipped    = clip_q;

	a_delay_shift: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m2_q == $past(m1_q))
		else $error("delay line did not shift on commit");

	a_delay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(m1_q) && $stable(m2_q))
		else $error("delay line moved without a commit");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(x_s1))
		else $error("stalled sample lost");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed sample gave no result");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		coef_bus.busy |=> !$past(commit))
		else $error("sample committed while cross terms settle");

endmodule
